// ===== rtl/core/tcw_pkg.sv =====
// shared constants, types and address helper for the text console writer
// depends on nothing; used by tcw_cell_ram and text_console_writer
package tcw_pkg;

	// screen geometry
	localparam int COLS      = 80;
	localparam int ROWS      = 25;
	localparam int TAB_WIDTH = 4;
	localparam int CELLS     = COLS * ROWS;

	// port widths
	localparam int FUNC_W = 2;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int ADDR_W = 11;
	localparam int TAB_W  = $clog2(TAB_WIDTH + 1);

	// derived constants at their widths
	localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(COLS);
	localparam logic [ADDR_W-1:0] COLS_M1_A   = ADDR_W'(COLS - 1);
	localparam logic [ADDR_W-1:0] CELLS_M1_A  = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] CELLS_A     = ADDR_W'(CELLS);
	localparam logic [ADDR_W:0]   CELLS_X     = (ADDR_W + 1)'(CELLS);
	localparam logic [COL_W-1:0]  COL_LAST    = COL_W'(COLS - 1);
	localparam logic [ROW_W-1:0]  ROW_LAST    = ROW_W'(ROWS - 1);
	localparam logic [TAB_W-1:0]  TAB_COUNT   = TAB_W'(TAB_WIDTH);

	// operation codes
	localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	// character codes
	localparam logic [CHAR_W-1:0] CODE_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CODE_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CODE_NL    = 8'h0A;
	localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
	localparam logic [ATTR_W-1:0] CLEAR_ATTR = 8'h07;

	typedef struct packed {
		logic [ATTR_W-1:0] attr;
		logic [CHAR_W-1:0] ch;
	} cell_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		cell_t             wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TAB,
		ST_BLANK,
		ST_RDATA
	} state_t;

	// logical cell index to memory index, rows kept as a ring from base
	function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] lin,
			input logic [ADDR_W-1:0] base);
		logic [ADDR_W:0] sum;
		sum = {1'b0, lin} + {1'b0, base};
		if (sum >= CELLS_X) begin
			sum = sum - CELLS_X;
		end
		return sum[ADDR_W-1:0];
	endfunction

endpackage

// ===== rtl/core/tcw_cell_ram.sv =====
// screen cell memory: one write port, one read port, registered read data
// depends on tcw_pkg for depth, address width and cell type
module tcw_cell_ram (
	input  logic              clk,
	input  tcw_pkg::ram_req_t req,
	output tcw_pkg::cell_t    rdata
);

	tcw_pkg::cell_t mem [0:tcw_pkg::CELLS-1];

	// write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

// ===== rtl/core/text_console_writer.sv =====
// text console writer top level: cursor and sequencer around the cell memory
// depends on tcw_pkg and tcw_cell_ram
//
//  channel   signals                                   direction  flow
//  command   start busy func char_code read_addr       in         beat when start && !busy
//  result    done cursor_col cursor_row cursor_offset  out        one-cycle strobe, no stall
//            read_char read_attr
//  config    cfg_valid cfg_ready cfg_data              in         beat when valid && ready
//
// result is registered and shows the cycle after an operation's last step: a printable
// byte, newline, return or backspace ends when accepted unless it scrolls; a read waits
// in ST_RDATA for the registered memory read; a tab has an accept cycle, then one cell
// write per blank. A scroll moves the ring base and blanks the new bottom row; clear
// sweeps all 2000 cells, one write per cycle; after reset the same sweep runs, busy high;
// config beats are taken. the result receiver cannot stall; cfg_ready is always high.
module text_console_writer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [tcw_pkg::FUNC_W-1:0]   func,
	input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
	input  logic [tcw_pkg::ADDR_W-1:0]   read_addr,
	output logic                         done,
	output logic [tcw_pkg::COL_W-1:0]    cursor_col,
	output logic [tcw_pkg::ROW_W-1:0]    cursor_row,
	output logic [tcw_pkg::ADDR_W-1:0]   cursor_offset,
	output logic [tcw_pkg::CHAR_W-1:0]   read_char,
	output logic [tcw_pkg::ATTR_W-1:0]   read_attr,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tcw_pkg::ATTR_W-1:0]   cfg_data
);

	localparam logic [tcw_pkg::TAB_W-1:0] TAB_ONE = tcw_pkg::TAB_W'(1);

	tcw_pkg::state_t state_q, state_d;
	logic [tcw_pkg::COL_W-1:0]  col_q, col_d;
	logic [tcw_pkg::ROW_W-1:0]  row_q, row_d;
	logic [tcw_pkg::ADDR_W-1:0] base_q, base_d;
	logic [tcw_pkg::ADDR_W-1:0] blank_base_q, blank_base_d;
	logic [tcw_pkg::ADDR_W-1:0] cnt_q, cnt_d;
	logic [tcw_pkg::TAB_W-1:0]  tab_q, tab_d;
	logic                       rd_ok_q, rd_ok_d;
	logic                       clr_report_q, clr_report_d;
	logic                       done_q;
	logic [tcw_pkg::ATTR_W-1:0] attr_q;
	logic [tcw_pkg::CHAR_W-1:0] rd_char_q;
	logic [tcw_pkg::ATTR_W-1:0] rd_attr_q;
	logic                       finish;
	logic                       scroll;

	tcw_pkg::ram_req_t ram_req;
	tcw_pkg::cell_t    ram_rdata;

	logic [tcw_pkg::ADDR_W-1:0] cur_lin;
	logic [tcw_pkg::ADDR_W-1:0] cur_phys;
	logic [tcw_pkg::ADDR_W-1:0] bs_phys;
	logic [tcw_pkg::ADDR_W:0]   base_sum;
	logic [tcw_pkg::ADDR_W-1:0] base_next;
	logic                       col_wrap;
	logic                       row_last;
	logic                       at_origin;

	tcw_cell_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	// cursor addressing
	assign cur_lin   = tcw_pkg::ADDR_W'(tcw_pkg::ADDR_W'(row_q) * tcw_pkg::COLS_A)
	                   + tcw_pkg::ADDR_W'(col_q);
	assign cur_phys  = tcw_pkg::phys_addr(cur_lin, base_q);
	assign bs_phys   = (cur_phys == '0) ? tcw_pkg::CELLS_M1_A : cur_phys - 1'b1;
	assign col_wrap  = (col_q == tcw_pkg::COL_LAST);
	assign row_last  = (row_q == tcw_pkg::ROW_LAST);
	assign at_origin = (col_q == '0) && (row_q == '0);

	// ring base after a scroll
	assign base_sum  = {1'b0, base_q} + {1'b0, tcw_pkg::COLS_A};
	assign base_next = (base_sum >= tcw_pkg::CELLS_X) ? '0 : base_sum[tcw_pkg::ADDR_W-1:0];

	// state register and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tcw_pkg::ST_CLEAR;
			col_q        <= '0;
			row_q        <= '0;
			base_q       <= '0;
			blank_base_q <= '0;
			cnt_q        <= '0;
			tab_q        <= '0;
			rd_ok_q      <= 1'b0;
			clr_report_q <= 1'b0;
			done_q       <= 1'b0;
			attr_q       <= tcw_pkg::CLEAR_ATTR;
		end else begin
			state_q      <= state_d;
			col_q        <= col_d;
			row_q        <= row_d;
			base_q       <= base_d;
			blank_base_q <= blank_base_d;
			cnt_q        <= cnt_d;
			tab_q        <= tab_d;
			rd_ok_q      <= rd_ok_d;
			clr_report_q <= clr_report_d;
			done_q       <= finish;
			if (cfg_valid && cfg_ready) begin
				attr_q <= cfg_data;
			end
		end
	end

	// read result fields, zero unless the finishing op is an in-range read
	always_ff @(posedge clk) begin
		if (finish) begin
			if (state_q == tcw_pkg::ST_RDATA && rd_ok_q) begin
				rd_char_q <= ram_rdata.ch;
				rd_attr_q <= ram_rdata.attr;
			end else begin
				rd_char_q <= '0;
				rd_attr_q <= '0;
			end
		end
	end

	// next state, cursor moves and memory requests
	always_comb begin
		state_d       = state_q;
		col_d         = col_q;
		row_d         = row_q;
		base_d        = base_q;
		blank_base_d  = blank_base_q;
		cnt_d         = cnt_q;
		tab_d         = tab_q;
		rd_ok_d       = rd_ok_q;
		clr_report_d  = clr_report_q;
		finish        = 1'b0;
		scroll        = 1'b0;
		ram_req.we    = 1'b0;
		ram_req.waddr = cur_phys;
		ram_req.wdata = '{attr: attr_q, ch: tcw_pkg::BLANK_CHAR};
		ram_req.re    = 1'b0;
		ram_req.raddr = tcw_pkg::phys_addr(read_addr, base_q);

		case (state_q)
			tcw_pkg::ST_CLEAR: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = cnt_q;
				ram_req.wdata = '{attr: tcw_pkg::CLEAR_ATTR, ch: tcw_pkg::BLANK_CHAR};
				cnt_d         = cnt_q + 1'b1;
				if (cnt_q == tcw_pkg::CELLS_M1_A) begin
					state_d      = tcw_pkg::ST_IDLE;
					finish       = clr_report_q;
					clr_report_d = 1'b0;
				end
			end

			tcw_pkg::ST_IDLE: begin
				if (start) begin
					case (func)
						tcw_pkg::FUNC_PUT: begin
							if (char_code == tcw_pkg::CODE_TAB) begin
								state_d = tcw_pkg::ST_TAB;
								tab_d   = tcw_pkg::TAB_COUNT;
							end else if (char_code == tcw_pkg::CODE_BS) begin
								finish = 1'b1;
								if (!at_origin) begin
									ram_req.we    = 1'b1;
									ram_req.waddr = bs_phys;
									if (col_q == '0) begin
										col_d = tcw_pkg::COL_LAST;
										row_d = row_q - 1'b1;
									end else begin
										col_d = col_q - 1'b1;
									end
								end
							end else if (char_code == tcw_pkg::CODE_NL
									|| char_code == tcw_pkg::CODE_CR) begin
								col_d = '0;
								if (row_last) begin
									scroll = 1'b1;
								end else begin
									row_d  = row_q + 1'b1;
									finish = 1'b1;
								end
							end else begin
								ram_req.we       = 1'b1;
								ram_req.wdata.ch = char_code;
								if (!col_wrap) begin
									col_d  = col_q + 1'b1;
									finish = 1'b1;
								end else if (row_last) begin
									scroll = 1'b1;
								end else begin
									col_d  = '0;
									row_d  = row_q + 1'b1;
									finish = 1'b1;
								end
							end
						end
						tcw_pkg::FUNC_READ: begin
							rd_ok_d    = (read_addr < tcw_pkg::CELLS_A);
							ram_req.re = (read_addr < tcw_pkg::CELLS_A);
							state_d    = tcw_pkg::ST_RDATA;
						end
						tcw_pkg::FUNC_CLEAR: begin
							state_d      = tcw_pkg::ST_CLEAR;
							clr_report_d = 1'b1;
							cnt_d        = '0;
							base_d       = '0;
							col_d        = '0;
							row_d        = '0;
						end
						default: begin
							finish = 1'b1;
						end
					endcase
				end
			end

			// one blank per cycle at the cursor, paused while a scroll blanks the new bottom row
			tcw_pkg::ST_TAB: begin
				ram_req.we = 1'b1;
				tab_d      = tab_q - 1'b1;
				if (!col_wrap) begin
					col_d = col_q + 1'b1;
				end else if (row_last) begin
					scroll = 1'b1;
				end else begin
					col_d = '0;
					row_d = row_q + 1'b1;
				end
				if (!scroll && tab_q == TAB_ONE) begin
					state_d = tcw_pkg::ST_IDLE;
					finish  = 1'b1;
				end
			end

			// blank the new bottom row after a scroll
			tcw_pkg::ST_BLANK: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = blank_base_q + cnt_q;
				cnt_d         = cnt_q + 1'b1;
				if (cnt_q == tcw_pkg::COLS_M1_A) begin
					if (tab_q != '0) begin
						state_d = tcw_pkg::ST_TAB;
					end else begin
						state_d = tcw_pkg::ST_IDLE;
						finish  = 1'b1;
					end
				end
			end

			tcw_pkg::ST_RDATA: begin
				state_d = tcw_pkg::ST_IDLE;
				finish  = 1'b1;
			end

			default: begin
				state_d = tcw_pkg::ST_IDLE;
			end
		endcase

		// scroll: old top row becomes the new bottom row
		if (scroll) begin
			col_d        = '0;
			row_d        = tcw_pkg::ROW_LAST;
			blank_base_d = base_q;
			base_d       = base_next;
			cnt_d        = '0;
			state_d      = tcw_pkg::ST_BLANK;
		end
	end

	// outputs
	assign busy          = (state_q != tcw_pkg::ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign done          = done_q;
	assign cursor_col    = col_q;
	assign cursor_row    = row_q;
	assign cursor_offset = cur_lin;
	assign read_char     = rd_char_q;
	assign read_attr     = rd_attr_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted command neither finished nor in progress");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= tcw_pkg::COL_LAST) && (row_q <= tcw_pkg::ROW_LAST)
		&& (base_q < tcw_pkg::CELLS_A))
		else $error("cursor or ring base out of range");

	a_tab_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> (tab_q == '0))
		else $error("tab count left over in idle");

	a_write_owner: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we |-> (busy || start))
		else $error("memory write with no operation");
`endif

endmodule
